>>> rtl/mail_header_scanner_assert.svh
// Assertion macros used by the checker file of the header scanner.
`ifndef MAIL_HEADER_SCANNER_ASSERT_SVH
`define MAIL_HEADER_SCANNER_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define MHS_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, quiet during reset.
`define MHS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

>>> rtl/mhs_pkg.sv
package mhs_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int COUNT_BITS  = 16;

    localparam int RC_BITS = 16;
    localparam int HB_BITS = 32;

    localparam int CNT_CMP_BITS = (COUNT_BITS > RC_BITS) ? COUNT_BITS : RC_BITS;
    localparam int LEN_CMP_BITS = (LENGTH_BITS > HB_BITS) ? LENGTH_BITS : HB_BITS;

    localparam int PREFIX_LEN = 9;
    localparam int POS_BITS   = 4;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [1:0] {
        PH_INLINE = 2'd0,
        PH_START  = 2'd1,
        PH_CR     = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Lower-case "received:" one letter per position.
    function automatic logic [7:0] prefix_char(input logic [POS_BITS-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "r";
            4'd1:    c = "e";
            4'd2:    c = "c";
            4'd3:    c = "e";
            4'd4:    c = "i";
            4'd5:    c = "v";
            4'd6:    c = "e";
            4'd7:    c = "d";
            4'd8:    c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // ASCII upper case to lower case; everything else passes unchanged.
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b inside {[8'h41:8'h5A]}) begin
            r = b + 8'd32;
        end
        return r;
    endfunction

endpackage

>>> rtl/mail_header_scanner.sv
// Channel  Beat handshake              Payload
// -------  --------------------------  ------------------------------------------------
// in       i_in_valid / o_in_ready     i_data_byte, i_last_byte
// out      o_out_valid / i_out_ready   o_received_count, o_header_bytes, o_header_found
//
// One message byte per clock while o_in_ready is high; the scan state updates in the cycle the byte is taken.
// A result appears in the cycle after the beat marked last, from the single result register.
// The input side keeps taking beats while a result waits, unless that result is stalled.
// Reset (i_rst_n low at a rising edge) puts the scanner at a line start with all counts zero.
module mail_header_scanner (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_last_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mhs_pkg::RC_BITS-1:0]  o_received_count,
    output logic [mhs_pkg::HB_BITS-1:0]  o_header_bytes,
    output logic                         o_header_found
);
    import mhs_pkg::*;

    // Scan state
    t_phase                 r_phase, n_phase;
    logic [POS_BITS-1:0]    r_match_pos, n_match_pos;
    logic                   r_alive, n_alive;
    logic [COUNT_BITS-1:0]  r_hit, n_hit;
    logic [LENGTH_BITS-1:0] r_byte_pos, n_byte_pos;
    logic [LENGTH_BITS-1:0] r_end_off, n_end_off;

    // Result register
    logic                   r_out_valid;
    logic [RC_BITS-1:0]     r_rc;
    logic [HB_BITS-1:0]     r_hb;
    logic                   r_found;

    logic                   accept;
    logic                   in_header;
    logic                   blank_line;
    logic [POS_BITS-1:0]    cur_pos;
    logic                   cur_alive;
    logic                   found;
    logic [LENGTH_BITS-1:0] len;
    logic [LEN_CMP_BITS-1:0] len_ext;
    logic [CNT_CMP_BITS-1:0] cnt_ext;
    logic [RC_BITS-1:0]     res_rc;
    logic [HB_BITS-1:0]     res_hb;

    // Take a beat unless a result is stalled at the output.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign in_header  = (r_phase != PH_DONE);
    // An LF at a line start, or after a CR that opened the line, closes the header.
    assign blank_line = in_header && (i_data_byte == CH_LF) &&
                        ((r_phase == PH_START) || (r_phase == PH_CR));

    // Line and header-end tracking.
    always_comb begin
        n_phase = r_phase;
        if (in_header) begin
            if (i_data_byte == CH_LF) begin
                if (r_phase == PH_START || r_phase == PH_CR) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_START;
                end
            end else if (i_data_byte == CH_CR && r_phase == PH_START) begin
                n_phase = PH_CR;
            end else begin
                n_phase = PH_INLINE;
            end
        end
    end

    // Prefix match, hit count and byte counting.
    always_comb begin
        n_byte_pos = r_byte_pos;
        if (r_byte_pos != '1) begin
            n_byte_pos = r_byte_pos + LENGTH_BITS'(1);
        end

        // A line start restarts the match from the first letter.
        cur_pos   = (r_phase == PH_START) ? '0 : r_match_pos;
        cur_alive = (r_phase == PH_START) ? 1'b1 : r_alive;

        n_match_pos = r_match_pos;
        n_alive     = r_alive;
        n_hit       = r_hit;
        n_end_off   = r_end_off;

        if (in_header) begin
            n_match_pos = cur_pos;
            n_alive     = cur_alive;
            if (cur_alive && (cur_pos < POS_BITS'(PREFIX_LEN))) begin
                if (fold_case(i_data_byte) == prefix_char(cur_pos)) begin
                    n_match_pos = cur_pos + POS_BITS'(1);
                    if (cur_pos == POS_BITS'(PREFIX_LEN - 1)) begin
                        // Full prefix seen: count the line, stop matching it.
                        if (r_hit != '1) begin
                            n_hit = r_hit + COUNT_BITS'(1);
                        end
                        n_alive = 1'b0;
                    end
                end else begin
                    n_alive = 1'b0;
                end
            end
        end

        if (blank_line) begin
            n_end_off = n_byte_pos;
        end
    end

    // Result values, saturated to the output widths.
    always_comb begin
        found   = (n_phase == PH_DONE);
        len     = found ? n_end_off : n_byte_pos;
        len_ext = LEN_CMP_BITS'(len);
        cnt_ext = CNT_CMP_BITS'(n_hit);
        res_hb  = (len_ext > LEN_CMP_BITS'({HB_BITS{1'b1}})) ? '1 : HB_BITS'(len_ext);
        res_rc  = (cnt_ext > CNT_CMP_BITS'({RC_BITS{1'b1}})) ? '1 : RC_BITS'(cnt_ext);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_match_pos <= '0;
            r_alive     <= 1'b1;
            r_hit       <= '0;
            r_byte_pos  <= '0;
            r_end_off   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last_byte) begin
                    // Message done: drop back to a fresh line start.
                    r_phase     <= PH_START;
                    r_match_pos <= '0;
                    r_alive     <= 1'b1;
                    r_hit       <= '0;
                    r_byte_pos  <= '0;
                    r_end_off   <= '0;
                end else begin
                    r_phase     <= n_phase;
                    r_match_pos <= n_match_pos;
                    r_alive     <= n_alive;
                    r_hit       <= n_hit;
                    r_byte_pos  <= n_byte_pos;
                    r_end_off   <= n_end_off;
                end
            end
            if (accept && i_last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result on the last beat; hold it otherwise.
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_rc    <= res_rc;
            r_hb    <= res_hb;
            r_found <= found;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_received_count = r_rc;
    assign o_header_bytes   = r_hb;
    assign o_header_found   = r_found;

endmodule

>>> rtl/mhs_checker.sv
`include "mail_header_scanner_assert.svh"

module mhs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_last_byte,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [mhs_pkg::RC_BITS-1:0]  o_received_count,
    input logic [mhs_pkg::HB_BITS-1:0]  o_header_bytes,
    input logic                         o_header_found
);
    import mhs_pkg::*;

    logic out_stall;
    logic in_beat;
    logic [RC_BITS+HB_BITS:0] out_payload;

    assign out_stall   = o_out_valid && !i_out_ready;
    assign in_beat     = i_in_valid && o_in_ready;
    assign out_payload = {o_received_count, o_header_bytes, o_header_found};

    `MHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid)
    `MHS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(out_payload))
    `MHS_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_beat && i_last_byte, o_out_valid)
    `MHS_ASSERT_NEXT(a_no_spurious_result, i_clk, i_rst_n,
                     in_beat && !i_last_byte && !o_out_valid, !o_out_valid)
    `MHS_ASSERT_NOW(a_length_nonzero, i_clk, i_rst_n, o_out_valid, o_header_bytes != '0)

endmodule

bind mail_header_scanner mhs_checker u_mhs_checker (.*);
